/* hdl/tsab_pkg.sv */
// Shared types and constants for the terrain slope and altitude blend block.
package tsab_pkg;

    // Field widths
    localparam int H_W      = 24;          // height, signed, 4 fraction bits
    localparam int SPAN_W   = 23;          // unsigned rock start and both span registers
    localparam int Q_W      = 16;          // quotient bits of a ramp division
    localparam int WGT_W    = 17;          // Q1.16 weight, 65536 means one
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Sideband carried through the snow divider: rock, scale, snow class
    localparam int DIV_SIDE_W = 2 * WGT_W + 2;

    localparam logic [WGT_W-1:0] ONE_Q16       = 17'd65536;
    localparam logic [15:0]      INV_SQRT2_Q16 = 16'd46341;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROCK_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROCK_SPAN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SNOW_START = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SNOW_SPAN  = 2'd3;

    // Register reset values
    localparam logic [SPAN_W-1:0]     ROCK_START_RST = 23'd96;
    localparam logic [SPAN_W-1:0]     ROCK_SPAN_RST  = 23'd32;
    localparam logic signed [H_W-1:0] SNOW_START_RST = 24'sd14400;
    localparam logic [SPAN_W-1:0]     SNOW_SPAN_RST  = 23'd1600;

    // Where a value sits on its ramp
    typedef enum logic [1:0] {
        CLS_ZERO,   // below start
        CLS_FULL,   // at or past start + span
        CLS_PART    // inside the ramp, needs a division
    } t_cls;

endpackage

/* hdl/tsab_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module tsab_div #(
    parameter int DW = tsab_pkg::SPAN_W,
    parameter int QW = tsab_pkg::Q_W,
    parameter int SW = tsab_pkg::DIV_SIDE_W
) (
    input  logic          i_clk,
    input  logic [QW-1:0] i_en,     // per-stage load enable
    input  logic [DW-1:0] i_rem,    // upper dividend bits, below i_div
    input  logic [QW-1:0] i_low,    // lower dividend bits
    input  logic [DW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic [QW-1:0] o_quot,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_low  [QW];
    logic [QW-1:0] r_quot [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quot_in;
        logic [SW-1:0] side_in;
        logic [DW:0]   trial;
        logic [DW:0]   sub;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = i_rem;
            assign low_in  = i_low;
            assign quot_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign low_in  = r_low[k-1];
            assign quot_in = r_quot[k-1];
            assign side_in = r_side[k-1];
        end

        // shift in the next dividend bit, then compare and subtract
        assign trial = {rem_in, low_in[QW-1]};
        assign ge    = (trial >= {1'b0, i_div});
        assign sub   = trial - {1'b0, i_div};

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k]  <= ge ? sub[DW-1:0] : trial[DW-1:0];
                r_low[k]  <= {low_in[QW-2:0], 1'b0};
                r_quot[k] <= {quot_in[QW-2:0], ge};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_quot = r_quot[QW-1];
    assign o_side = r_side[QW-1];

endmodule

/* hdl/terrain_slope_altitude_blend.sv */
// Top level: slope from a 3x3 height window, rock and snow blend weights.
// While o_ready is high one request per clock is accepted, and while i_ready
// is high one result per clock is delivered. A request passes through DIFF,
// DIAG, MAX4, MAX1, RCLS, the rock divider, ROCK, MUL, the snow divider and
// OUT in that order. The depth is set by the two 16-stage restoring dividers,
// one for the rock ramp and one for the snow ramp, that run in series because
// the snow weight is scaled by (1 - rock). Each stage holds its own valid bit
// and loads whenever it or any stage downstream of it is empty or the output
// is taken, so bubbles are squeezed out and o_ready stays high while the
// output waits, until every stage is full. Configuration writes take effect
// at once and are meant for when the pipeline is empty.
module terrain_slope_altitude_blend (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [tsab_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tsab_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // request channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [tsab_pkg::H_W-1:0]    i_h_center,
    input  logic signed [tsab_pkg::H_W-1:0]    i_h_up_left,
    input  logic signed [tsab_pkg::H_W-1:0]    i_h_up,
    input  logic signed [tsab_pkg::H_W-1:0]    i_h_up_right,
    input  logic signed [tsab_pkg::H_W-1:0]    i_h_left,
    input  logic signed [tsab_pkg::H_W-1:0]    i_h_right,
    input  logic signed [tsab_pkg::H_W-1:0]    i_h_down_left,
    input  logic signed [tsab_pkg::H_W-1:0]    i_h_down,
    input  logic signed [tsab_pkg::H_W-1:0]    i_h_down_right,
    // result channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [tsab_pkg::WGT_W-1:0]         o_rock_weight,
    output logic [tsab_pkg::WGT_W-1:0]         o_snow_weight
);

    localparam int H_W    = tsab_pkg::H_W;
    localparam int SPAN_W = tsab_pkg::SPAN_W;
    localparam int Q_W    = tsab_pkg::Q_W;
    localparam int WGT_W  = tsab_pkg::WGT_W;
    localparam int SIDE_W = tsab_pkg::DIV_SIDE_W;
    localparam int RSIDE_W = 2 + SPAN_W + 2;     // snow class, altitude offset, rock class

    // stage map
    localparam int ST_DIFF  = 0;
    localparam int ST_DIAG  = 1;
    localparam int ST_MAX4  = 2;
    localparam int ST_MAX1  = 3;
    localparam int ST_RCLS  = 4;
    localparam int ST_RDIV  = 5;
    localparam int ST_ROCK  = ST_RDIV + Q_W;
    localparam int ST_MUL   = ST_ROCK + 1;
    localparam int ST_SDIV  = ST_MUL + 1;
    localparam int ST_OUT   = ST_SDIV + Q_W;
    localparam int NS       = ST_OUT + 1;

    // ---------------------------------------------------------------
    // Configuration registers
    logic [SPAN_W-1:0]     r_rock_start;
    logic [SPAN_W-1:0]     r_rock_span;
    logic signed [H_W-1:0] r_snow_start;
    logic [SPAN_W-1:0]     r_snow_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rock_start <= tsab_pkg::ROCK_START_RST;
            r_rock_span  <= tsab_pkg::ROCK_SPAN_RST;
            r_snow_start <= tsab_pkg::SNOW_START_RST;
            r_snow_span  <= tsab_pkg::SNOW_SPAN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tsab_pkg::REG_ROCK_START: r_rock_start <= i_cfg_data[SPAN_W-1:0];
                tsab_pkg::REG_ROCK_SPAN:  r_rock_span  <= i_cfg_data[SPAN_W-1:0];
                tsab_pkg::REG_SNOW_START: r_snow_start <= $signed(i_cfg_data[H_W-1:0]);
                tsab_pkg::REG_SNOW_SPAN:  r_snow_span  <= i_cfg_data[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage enables and valid bits: a stage loads when it or any later
    // stage is empty, or when the output is being taken
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS-1:0] en;
    logic [NS-1:0] prev_v;

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            en[k] = i_ready || (((~r_v) >> k) != '0);
        end
    end

    assign prev_v = {r_v[NS-2:0], i_valid};
    assign n_v    = (en & prev_v) | (~en & r_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];

    // ---------------------------------------------------------------
    // Stage DIFF: absolute neighbor differences, snow ramp class
    logic signed [H_W-1:0] nb [8];
    logic [7:0]            is_diag;
    logic [H_W-1:0]        mag [8];
    logic signed [H_W:0]   alt_off;
    tsab_pkg::t_cls        snow_cls;

    assign nb[0] = i_h_up_left;
    assign nb[1] = i_h_up;
    assign nb[2] = i_h_up_right;
    assign nb[3] = i_h_left;
    assign nb[4] = i_h_right;
    assign nb[5] = i_h_down_left;
    assign nb[6] = i_h_down;
    assign nb[7] = i_h_down_right;
    assign is_diag = 8'b1010_0101;

    always_comb begin
        logic signed [H_W:0] d;
        for (int k = 0; k < 8; k++) begin
            d = {nb[k][H_W-1], nb[k]} - {i_h_center[H_W-1], i_h_center};
            mag[k] = d[H_W] ? H_W'(-d) : d[H_W-1:0];
        end
    end

    always_comb begin
        alt_off = {i_h_center[H_W-1], i_h_center} - {r_snow_start[H_W-1], r_snow_start};
        if (alt_off[H_W]) begin
            snow_cls = tsab_pkg::CLS_ZERO;
        end else if (alt_off[H_W-1:0] >= {1'b0, r_snow_span}) begin
            snow_cls = tsab_pkg::CLS_FULL;
        end else begin
            snow_cls = tsab_pkg::CLS_PART;
        end
    end

    logic [H_W-1:0]    r_s1_mag [8];
    tsab_pkg::t_cls    r_s1_scls;
    logic [SPAN_W-1:0] r_s1_alt;

    always_ff @(posedge i_clk) begin
        if (en[ST_DIFF]) begin
            r_s1_mag  <= mag;
            r_s1_scls <= snow_cls;
            r_s1_alt  <= alt_off[SPAN_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage DIAG: scale diagonal differences by 1/sqrt(2)
    logic [H_W-1:0]    scaled [8];
    logic [H_W-1:0]    r_s2_d [8];
    tsab_pkg::t_cls    r_s2_scls;
    logic [SPAN_W-1:0] r_s2_alt;

    always_comb begin
        logic [H_W+15:0] p;
        for (int k = 0; k < 8; k++) begin
            p = r_s1_mag[k] * tsab_pkg::INV_SQRT2_Q16;
            scaled[k] = is_diag[k] ? p[H_W+15:16] : r_s1_mag[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_DIAG]) begin
            r_s2_d    <= scaled;
            r_s2_scls <= r_s1_scls;
            r_s2_alt  <= r_s1_alt;
        end
    end

    // ---------------------------------------------------------------
    // Stages MAX4 and MAX1: maximum tree
    function automatic logic [H_W-1:0] max_h(input logic [H_W-1:0] a, input logic [H_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [H_W-1:0]    r_s3_m [4];
    tsab_pkg::t_cls    r_s3_scls;
    logic [SPAN_W-1:0] r_s3_alt;

    always_ff @(posedge i_clk) begin
        if (en[ST_MAX4]) begin
            for (int k = 0; k < 4; k++) begin
                r_s3_m[k] <= max_h(r_s2_d[2*k], r_s2_d[2*k+1]);
            end
            r_s3_scls <= r_s2_scls;
            r_s3_alt  <= r_s2_alt;
        end
    end

    logic [H_W-1:0]    r_s4_slope;
    tsab_pkg::t_cls    r_s4_scls;
    logic [SPAN_W-1:0] r_s4_alt;

    always_ff @(posedge i_clk) begin
        if (en[ST_MAX1]) begin
            r_s4_slope <= max_h(max_h(r_s3_m[0], r_s3_m[1]), max_h(r_s3_m[2], r_s3_m[3]));
            r_s4_scls  <= r_s3_scls;
            r_s4_alt   <= r_s3_alt;
        end
    end

    // ---------------------------------------------------------------
    // Stage RCLS: place the slope on the rock ramp
    logic signed [H_W:0] slope_off;
    tsab_pkg::t_cls      rock_cls;

    always_comb begin
        slope_off = {1'b0, r_s4_slope} - {2'b00, r_rock_start};
        if (slope_off[H_W]) begin
            rock_cls = tsab_pkg::CLS_ZERO;
        end else if (slope_off[H_W-1:0] >= {1'b0, r_rock_span}) begin
            rock_cls = tsab_pkg::CLS_FULL;
        end else begin
            rock_cls = tsab_pkg::CLS_PART;
        end
    end

    logic [SPAN_W-1:0]  r_s5_num;
    logic [RSIDE_W-1:0] r_s5_side;

    always_ff @(posedge i_clk) begin
        if (en[ST_RCLS]) begin
            r_s5_num  <= slope_off[SPAN_W-1:0];
            r_s5_side <= {r_s4_scls, r_s4_alt, rock_cls};
        end
    end

    // ---------------------------------------------------------------
    // Rock divider: (slope - start) * 65536 / span
    logic [Q_W-1:0]     rock_quot;
    logic [RSIDE_W-1:0] rock_side;

    tsab_div #(
        .DW (SPAN_W),
        .QW (Q_W),
        .SW (RSIDE_W)
    ) u_rock_div (
        .i_clk  (i_clk),
        .i_en   (en[ST_RDIV +: Q_W]),
        .i_rem  (r_s5_num),
        .i_low  ('0),
        .i_div  (r_rock_span),
        .i_side (r_s5_side),
        .o_quot (rock_quot),
        .o_side (rock_side)
    );

    // ---------------------------------------------------------------
    // Stage ROCK: resolve rock weight, snow scale = 1 - rock
    tsab_pkg::t_cls    rd_rcls;
    tsab_pkg::t_cls    rd_scls;
    logic [SPAN_W-1:0] rd_alt;
    logic [WGT_W-1:0]  rock_w;

    assign rd_rcls = tsab_pkg::t_cls'(rock_side[1:0]);
    assign rd_alt  = rock_side[SPAN_W+1:2];
    assign rd_scls = tsab_pkg::t_cls'(rock_side[RSIDE_W-1 -: 2]);

    always_comb begin
        case (rd_rcls)
            tsab_pkg::CLS_ZERO: rock_w = '0;
            tsab_pkg::CLS_FULL: rock_w = tsab_pkg::ONE_Q16;
            default:            rock_w = {1'b0, rock_quot};
        endcase
    end

    logic [WGT_W-1:0]  r_s6_rock;
    logic [WGT_W-1:0]  r_s6_scale;
    tsab_pkg::t_cls    r_s6_scls;
    logic [SPAN_W-1:0] r_s6_alt;

    always_ff @(posedge i_clk) begin
        if (en[ST_ROCK]) begin
            r_s6_rock  <= rock_w;
            r_s6_scale <= tsab_pkg::ONE_Q16 - rock_w;
            r_s6_scls  <= rd_scls;
            r_s6_alt   <= rd_alt;
        end
    end

    // ---------------------------------------------------------------
    // Stage MUL: scale * altitude offset
    logic [WGT_W+SPAN_W-1:0] r_s7_prod;
    logic [SIDE_W-1:0]       r_s7_side;

    always_ff @(posedge i_clk) begin
        if (en[ST_MUL]) begin
            r_s7_prod <= r_s6_scale * r_s6_alt;
            r_s7_side <= {r_s6_rock, r_s6_scale, r_s6_scls};
        end
    end

    // ---------------------------------------------------------------
    // Snow divider: scale * (h - start) / span
    logic [Q_W-1:0]    snow_quot;
    logic [SIDE_W-1:0] snow_side;

    tsab_div #(
        .DW (SPAN_W),
        .QW (Q_W),
        .SW (SIDE_W)
    ) u_snow_div (
        .i_clk  (i_clk),
        .i_en   (en[ST_SDIV +: Q_W]),
        .i_rem  (r_s7_prod[SPAN_W+Q_W-1:Q_W]),
        .i_low  (r_s7_prod[Q_W-1:0]),
        .i_div  (r_snow_span),
        .i_side (r_s7_side),
        .o_quot (snow_quot),
        .o_side (snow_side)
    );

    // ---------------------------------------------------------------
    // Stage OUT: resolve snow weight, output registers
    tsab_pkg::t_cls   sd_scls;
    logic [WGT_W-1:0] sd_scale;
    logic [WGT_W-1:0] sd_rock;
    logic [WGT_W-1:0] snow_w;

    assign sd_scls  = tsab_pkg::t_cls'(snow_side[1:0]);
    assign sd_scale = snow_side[WGT_W+1:2];
    assign sd_rock  = snow_side[SIDE_W-1 -: WGT_W];

    always_comb begin
        case (sd_scls)
            tsab_pkg::CLS_ZERO: snow_w = '0;
            tsab_pkg::CLS_FULL: snow_w = sd_scale;
            default:            snow_w = {1'b0, snow_quot};
        endcase
    end

    logic [WGT_W-1:0] r_out_rock;
    logic [WGT_W-1:0] r_out_snow;

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_out_rock <= sd_rock;
            r_out_snow <= snow_w;
        end
    end

    assign o_rock_weight = r_out_rock;
    assign o_snow_weight = r_out_snow;

`ifndef NO_ASSERTIONS
    // the two weights never add up past one
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_rock_weight} + {1'b0, o_snow_weight})
                    <= {1'b0, tsab_pkg::ONE_Q16})
        else $error("rock + snow weight exceeds one");

    // full rock leaves no room for snow
    a_full_rock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rock_weight == tsab_pkg::ONE_Q16) |-> o_snow_weight == '0)
        else $error("snow weight nonzero under full rock");

    // a result only appears if the stage before it held a request
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v[NS-1]) |-> $past(r_v[NS-2]))
        else $error("output valid without upstream request");

    // reset empties the whole pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_v == '0)
        else $error("pipeline not empty after reset");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the terrain slope and altitude blend block.

typedef logic signed [tsab_pkg::H_W-1:0] t_window [9];

typedef struct {
    logic [tsab_pkg::WGT_W-1:0] rock;
    logic [tsab_pkg::WGT_W-1:0] snow;
    int                         tag;
} t_weights;

// Neighbor order: up-left, up, up-right, left, right, down-left, down, down-right
localparam logic [7:0] DIAG_MASK = 8'b1010_0101;
localparam longint INV_ROOT2_Q16 = 46341;
localparam longint WEIGHT_ONE = 65536;
localparam logic signed [23:0] H_MAX = 24'sh7FFFFF;
localparam logic signed [23:0] H_MIN = 24'sh800000;

// Predicts the blend weights of each accepted request and checks the results
class weight_checker;
    logic [tsab_pkg::SPAN_W-1:0] rock_start;
    logic [tsab_pkg::SPAN_W-1:0] rock_span;
    logic signed [tsab_pkg::H_W-1:0] snow_start;
    logic [tsab_pkg::SPAN_W-1:0] snow_span;
    t_weights expected_weights[$];
    int failures;
    int accepted;

    function new();
        rock_start = 23'd96;
        rock_span  = 23'd32;
        snow_start = 24'sd14400;
        snow_span  = 23'd1600;
        failures   = 0;
        accepted   = 0;
    endfunction

    // Registers keep the low bits of the written word
    function void write_reg(logic [tsab_pkg::CFG_IDX_W-1:0] idx,
                            logic [tsab_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            tsab_pkg::REG_ROCK_START: rock_start = data[22:0];
            tsab_pkg::REG_ROCK_SPAN:  rock_span  = data[22:0];
            tsab_pkg::REG_SNOW_START: snow_start = data;
            tsab_pkg::REG_SNOW_SPAN:  snow_span  = data[22:0];
            default: ;
        endcase
    endfunction

    // Position of v on [start, start+span), scaled; a zero span is a step
    function longint ramp(longint v, longint start, longint span, longint scale);
        if (v < start)
            return 0;
        if (span <= 0 || v >= start + span)
            return scale;
        return (scale * (v - start)) / span;
    endfunction

    function void note_window(t_window w);
        longint center, nb, d, slope, rock, snow;
        t_weights e;
        center = w[0];
        slope  = 0;
        for (int k = 0; k < 8; k++) begin
            nb = w[k+1];
            d  = (nb > center) ? nb - center : center - nb;
            if (DIAG_MASK[k])
                d = (d * INV_ROOT2_Q16) >>> 16;
            if (d > slope)
                slope = d;
        end
        rock = ramp(slope, longint'(rock_start), longint'(rock_span), WEIGHT_ONE);
        snow = ramp(center, longint'(snow_start), longint'(snow_span), WEIGHT_ONE - rock);
        e.rock = rock[16:0];
        e.snow = snow[16:0];
        e.tag  = accepted;
        accepted++;
        expected_weights.insert(expected_weights.size(), e);
    endfunction

    function void check_weights(logic [16:0] rock, logic [16:0] snow);
        t_weights e;
        if (expected_weights.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("ERROR: result with no request pending: rock %0d snow %0d",
                         rock, snow);
            return;
        end
        e = expected_weights.pop_front();
        if (rock !== e.rock || snow !== e.snow) begin
            failures++;
            if (failures <= 10)
                $display("ERROR: request %0d: rock exp %0d got %0d, snow exp %0d got %0d",
                         e.tag, e.rock, rock, e.snow, snow);
        end
    endfunction

    function int pending();
        return expected_weights.size();
    endfunction
endclass

module tb_top;

    localparam int ITEMS_PER_PHASE = 180;
    localparam int NUM_PHASES      = 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 60;
    localparam int CYCLE_LIMIT     = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tsab_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [tsab_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [tsab_pkg::H_W-1:0] i_h_center = '0;
    logic signed [tsab_pkg::H_W-1:0] i_h_up_left = '0;
    logic signed [tsab_pkg::H_W-1:0] i_h_up = '0;
    logic signed [tsab_pkg::H_W-1:0] i_h_up_right = '0;
    logic signed [tsab_pkg::H_W-1:0] i_h_left = '0;
    logic signed [tsab_pkg::H_W-1:0] i_h_right = '0;
    logic signed [tsab_pkg::H_W-1:0] i_h_down_left = '0;
    logic signed [tsab_pkg::H_W-1:0] i_h_down = '0;
    logic signed [tsab_pkg::H_W-1:0] i_h_down_right = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [tsab_pkg::WGT_W-1:0] o_rock_weight;
    logic [tsab_pkg::WGT_W-1:0] o_snow_weight;

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit hold_req = 1'b0;
    int unsigned cycle_count = 0;

    weight_checker board;

    terrain_slope_altitude_blend dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_h_center     (i_h_center),
        .i_h_up_left    (i_h_up_left),
        .i_h_up         (i_h_up),
        .i_h_up_right   (i_h_up_right),
        .i_h_left       (i_h_left),
        .i_h_right      (i_h_right),
        .i_h_down_left  (i_h_down_left),
        .i_h_down       (i_h_down),
        .i_h_down_right (i_h_down_right),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_rock_weight  (o_rock_weight),
        .o_snow_weight  (o_snow_weight)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int idle_length(int longest);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, longest);
    endfunction

    function automatic logic signed [23:0] clamp_h(longint v);
        if (v > longint'(H_MAX))
            return H_MAX;
        if (v < longint'(H_MIN))
            return H_MIN;
        return v[23:0];
    endfunction

    function automatic t_window flat_window(logic signed [23:0] c, logic signed [23:0] n);
        t_window w;
        w[0] = c;
        for (int k = 1; k < 9; k++)
            w[k] = n;
        return w;
    endfunction

    // Mostly windows aimed at the current ramps, some corners and pure noise
    function automatic t_window random_window();
        t_window w;
        longint c, t, delta, r;
        int mode, pick;
        mode = $urandom_range(0, 99);
        if (mode < 10) begin
            for (int k = 0; k < 9; k++)
                w[k] = 24'($urandom);
            return w;
        end
        if (mode < 16) begin
            for (int k = 0; k < 9; k++)
                case ($urandom_range(0, 4))
                    0:       w[k] = H_MIN;
                    1:       w[k] = H_MAX;
                    2:       w[k] = 24'sd0;
                    3:       w[k] = -24'sd1;
                    default: w[k] = 24'($urandom);
                endcase
            return w;
        end
        // center mostly near the altitude ramp, otherwise random
        if ($urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, 2 * int'(board.snow_span) + 4);
            c = longint'(board.snow_start) + r - 2;
        end else begin
            w[0] = 24'($urandom);
            c = w[0];
        end
        c = clamp_h(c);
        // steepest difference mostly near the slope ramp
        case ($urandom_range(0, 9))
            0, 1: t = $urandom_range(0, 3000);
            2:    t = $urandom_range(0, 24'hFFFFFF);
            default: begin
                r = $urandom_range(0, 2 * int'(board.rock_span) + 4);
                t = longint'(board.rock_start) + r - 2;
            end
        endcase
        if (t < 0)
            t = 0;
        pick = $urandom_range(0, 7);
        w[0] = c[23:0];
        for (int k = 0; k < 8; k++) begin
            if (k != pick)
                delta = $urandom_range(0, int'(t));
            else if (DIAG_MASK[k])
                delta = (t * 65536 + INV_ROOT2_Q16 - 1) / INV_ROOT2_Q16
                        - $urandom_range(0, 1);
            else
                delta = t;
            if ($urandom_range(0, 1))
                delta = -delta;
            w[k+1] = clamp_h(c + delta);
        end
        return w;
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_window(input t_window w);
        int gap;
        gap = tx_calm ? 0 : idle_length(24);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_h_center     <= w[0];
        i_h_up_left    <= w[1];
        i_h_up         <= w[2];
        i_h_up_right   <= w[3];
        i_h_left       <= w[4];
        i_h_right      <= w[5];
        i_h_down_left  <= w[6];
        i_h_down       <= w[7];
        i_h_down_right <= w[8];
        do @(posedge i_clk); while (!o_ready);
        board.note_window(w);
    endtask

    // Stop offering and wait until every result is back
    task automatic settle_pipeline();
        i_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_register(input logic [tsab_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [tsab_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_ramps(input logic [23:0] rs, input logic [23:0] rsp,
                             input logic [23:0] ss, input logic [23:0] ssp);
        load_register(tsab_pkg::REG_ROCK_START, rs);
        load_register(tsab_pkg::REG_ROCK_SPAN, rsp);
        load_register(tsab_pkg::REG_SNOW_START, ss);
        load_register(tsab_pkg::REG_SNOW_SPAN, ssp);
    endtask

    // Result side: check, then pick the ready level for the next cycle
    initial begin
        int stall_left;
        stall_left = 0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                board.check_weights(o_rock_weight, o_snow_weight);
            if (hold_req) begin
                stall_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if (stall_left == 0 && !rx_calm) begin
                stall_left = idle_length(40);
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus
    initial begin
        t_window w;
        int c_list[4];
        int d_list[4];
        c_list = '{14399, 14400, 15999, 16000};
        d_list = '{95, 96, 127, 128};
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed windows under the reset ramps
        send_window(flat_window(24'sd0, 24'sd0));
        send_window(flat_window(H_MAX, H_MAX));
        send_window(flat_window(H_MIN, H_MIN));
        send_window(flat_window(H_MIN, H_MAX));
        send_window(flat_window(H_MAX, H_MIN));
        // each neighbor alone carries the slope, up and down
        for (int k = 0; k < 8; k++) begin
            w = flat_window(24'sd15200, 24'sd15200);
            w[k+1] = (k % 2 == 0) ? 24'sd15310 : 24'sd15090;
            send_window(w);
        end
        // slope and altitude right at the ramp ends
        for (int k = 0; k < 4; k++) begin
            w = flat_window(24'(c_list[k]), 24'(c_list[k]));
            w[2] = 24'(c_list[k] + d_list[k]);
            send_window(w);
        end
        // diagonal rounding across the rock start
        w = flat_window(24'sd15000, 24'sd15000);
        w[3] = 24'sd15136;
        send_window(w);
        w = flat_window(24'sd15000, 24'sd15000);
        w[8] = 24'sd14865;
        send_window(w);

        // Random phases, each under its own ramp setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                settle_pipeline();
                case (ph)
                    1: set_ramps(24'd0, 24'd1, 24'h800000, 24'd1);
                    2: set_ramps(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
                    // zero spans, with the unused top bit set on two of them
                    3: set_ramps(24'h8000C8, 24'd0, 24'd0, 24'h800000);
                    7: set_ramps(24'($urandom), 24'($urandom), 24'($urandom),
                                 24'($urandom));
                    default: set_ramps({1'($urandom), 23'($urandom_range(0, 3000))},
                                       {1'($urandom), 23'($urandom_range(1, 4000))},
                                       24'($urandom),
                                       {1'($urandom), 23'($urandom_range(1, 200000))});
                endcase
            end
            tx_calm = (ph == 5 || ph == 6);
            rx_calm = (ph == 6);
            // long receiver hold-off while requests keep coming
            if (ph == 5)
                hold_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 5 && n == 150)
                    tx_calm = 1'b0;
                send_window(random_window());
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        settle_pipeline();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
